@@ hw/rtl/dntbl_pkg.sv @@
// Shared types, codes and helpers for the directory name table.
package dntbl_pkg;

   localparam int NAME_W      = 256;
   localparam int NODE_IDX_W  = 16;
   localparam int CSR_W       = 7;
   localparam logic [CSR_W-1:0] CSR_RESET = 7'd64;

   typedef enum logic [1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_LOOKUP = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXISTS    = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      mode_type                mode;
      logic [63:0]             name_word0;
      logic [63:0]             name_word1;
      logic [63:0]             name_word2;
      logic [63:0]             name_word3;
      logic [NODE_IDX_W-1:0]   node_index;
   } req_item_type;

   typedef struct packed {
      status_type              status;
      logic [NODE_IDX_W-1:0]   found_index;
   } rsp_item_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_wr;
      logic load;
      logic scan_rd;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic cnt_zero;
   } stat_type;

   // Zero every byte after the first zero byte of the name
   function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
      logic [NAME_W-1:0] res;
      logic              keep;
      res  = '0;
      keep = 1'b1;
      for (int b = 0; b < NAME_W / 8; b++) begin
         res[b*8 +: 8] = keep ? raw[b*8 +: 8] : 8'd0;
         keep          = keep & (raw[b*8 +: 8] != 8'd0);
      end
      return res;
   endfunction

endpackage

@@ hw/rtl/dntbl_ctrl.sv @@
// Controller state machine: clearing pass, scan sequencing and commit.
module dntbl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dntbl_pkg::stat_type stat,
   output dntbl_pkg::cmd_type  cmd
);
   import dntbl_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = stat.cnt_zero ? S_FINISH : S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

`ifndef NO_ASSERTIONS
   // A scan always ends with a drain and then a commit
   a_drain_then_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |=> (state_ff == S_FINISH))
      else $error("drain not followed by finish");
   // Only one command at a time
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command");
`endif

endmodule

@@ hw/rtl/dntbl_dp.sv @@
// Datapath: entry memories, scan compare, match and free tracking, result.
module dntbl_dp #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dntbl_pkg::req_item_type    req_item,
   input  logic                       csr_wr_en,
   input  logic [dntbl_pkg::CSR_W-1:0] csr_wr_data,
   input  dntbl_pkg::cmd_type         cmd,
   output dntbl_pkg::stat_type        stat,
   output logic                       rsp_valid,
   output dntbl_pkg::rsp_item_type    rsp_item
);
   import dntbl_pkg::*;

   localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int NW  = (CW > CSR_W) ? CW : CSR_W;

   // Entry stores
   logic [NAME_W-1:0]     name_mem  [MAX_ENTRIES];
   logic [NODE_IDX_W-1:0] index_mem [MAX_ENTRIES];

   logic [CSR_W-1:0]      csr_ff;
   logic [AW-1:0]         addr_ff;
   mode_type              mode_ff;
   logic [NAME_W-1:0]     name_ff;
   logic [NODE_IDX_W-1:0] node_ff;

   logic                  rd_vld_ff;
   logic [AW-1:0]         rd_addr_ff;
   logic [NAME_W-1:0]     rd_name_ff;
   logic [NODE_IDX_W-1:0] rd_index_ff;

   logic                  match_hit_ff;
   logic [AW-1:0]         match_pos_ff;
   logic [NODE_IDX_W-1:0] match_idx_ff;
   logic                  free_hit_ff;
   logic [AW-1:0]         free_pos_ff;

   logic                  rsp_valid_ff;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   logic [NW-1:0]         cfg_ext, cnt, cnt_m1;
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [NAME_W-1:0]     mem_wname;
   logic [NODE_IDX_W-1:0] mem_windex;
   logic                  hit_now, free_now;

   // Hold the entry count register
   always_ff @(posedge clock) begin
      if (reset)          csr_ff <= CSR_RESET;
      else if (csr_wr_en) csr_ff <= csr_wr_data;
   end

   // Clamp the count to the table size
   assign cfg_ext = NW'(csr_ff);
   assign cnt     = (cfg_ext > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : cfg_ext;
   assign cnt_m1  = cnt - NW'(1);

   assign stat.cnt_zero   = (cnt == '0);
   assign stat.scan_last  = (NW'(addr_ff) == cnt_m1);
   assign stat.clear_last = (addr_ff == AW'(MAX_ENTRIES - 1));

   // Advance the entry address
   always_ff @(posedge clock) begin
      if (reset)                         addr_ff <= '0;
      else if (cmd.load)                 addr_ff <= '0;
      else if (cmd.clear_wr || cmd.scan_rd) addr_ff <= addr_ff + AW'(1);
   end

   // Capture the item with its name trimmed at the first zero byte
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_item.mode;
         name_ff <= canon_name({req_item.name_word3, req_item.name_word2,
                                req_item.name_word1, req_item.name_word0});
         node_ff <= req_item.node_index;
      end
   end

   // Read one entry per cycle
   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         rd_name_ff  <= name_mem[addr_ff];
         rd_index_ff <= index_mem[addr_ff];
         rd_addr_ff  <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= cmd.scan_rd;
   end

   // Track the lowest match and the lowest free entry
   assign hit_now  = rd_vld_ff && !match_hit_ff && (rd_name_ff == name_ff);
   assign free_now = rd_vld_ff && !free_hit_ff && (rd_name_ff[7:0] == 8'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
      end else if (cmd.load) begin
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
      end else begin
         if (hit_now)  match_hit_ff <= 1'b1;
         if (free_now) free_hit_ff  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hit_now) begin
         match_pos_ff <= rd_addr_ff;
         match_idx_ff <= rd_index_ff;
      end
      if (free_now) free_pos_ff <= rd_addr_ff;
   end

   // Select the write and the result
   always_comb begin
      mem_we      = 1'b0;
      mem_waddr   = addr_ff;
      mem_wname   = '0;
      mem_windex  = '0;
      rsp_item_in = '{status: ST_NOT_FOUND, found_index: '0};
      if (cmd.clear_wr) begin
         mem_we = 1'b1;
      end else if (cmd.finish) begin
         unique case (mode_ff)
            MODE_ADD: begin
               if (match_hit_ff) begin
                  rsp_item_in.status = ST_EXISTS;
               end else if (free_hit_ff) begin
                  rsp_item_in.status = ST_OK;
                  mem_we     = 1'b1;
                  mem_waddr  = free_pos_ff;
                  mem_wname  = name_ff;
                  mem_windex = node_ff;
               end else begin
                  rsp_item_in.status = ST_FULL;
               end
            end
            MODE_REMOVE: begin
               if (match_hit_ff) begin
                  rsp_item_in.status      = ST_OK;
                  rsp_item_in.found_index = match_idx_ff;
                  mem_we    = 1'b1;
                  mem_waddr = match_pos_ff;
               end
            end
            MODE_LOOKUP: begin
               if (match_hit_ff) begin
                  rsp_item_in.status      = ST_OK;
                  rsp_item_in.found_index = match_idx_ff;
               end
            end
            default: begin
               rsp_item_in.status = ST_NOT_FOUND;
            end
         endcase
      end
   end

   // Write the entry stores
   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[mem_waddr]  <= mem_wname;
         index_mem[mem_waddr] <= mem_windex;
      end
   end

   // Drive the result for one cycle
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   // An add never writes over the table when the name is already there
   a_no_dup_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && mode_ff == MODE_ADD && match_hit_ff) |-> !mem_we)
      else $error("add wrote despite existing name");
   // Scan reads stay inside the searched range
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_rd |-> (NW'(addr_ff) < cnt))
      else $error("scan beyond entry count");
   // One result strobe per item
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back to back result strobes");
`endif

endmodule

@@ hw/rtl/directory_name_table_core.sv @@
// Top level of the directory name table: controller plus datapath.
// An item (add, remove or look up of a 32-byte name) is accepted when start is
// high and busy is low. The scan covers the first n entries, where n is the
// entry count written through csr_wr_data clamped to MAX_ENTRIES: the name
// memory has one read port, so the scan reads one entry per cycle, followed
// by a drain state for the last compare and a commit state. With n zero the
// scan and drain are skipped. The result appears on rsp_item for exactly one
// cycle with rsp_valid, the cycle after the commit; the receiver cannot stall
// it. After reset the block clears every entry, one per cycle, holding busy high.
module directory_name_table_core #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  dntbl_pkg::req_item_type     req_item,
   output logic                        rsp_valid,
   output dntbl_pkg::rsp_item_type     rsp_item,
   input  logic                        csr_wr_en,
   input  logic [dntbl_pkg::CSR_W-1:0] csr_wr_data
);
   import dntbl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   dntbl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   dntbl_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule
